/* hdl/svpg_pkg.sv */
// shared types and constants of the spectrum video pixel generator
package svpg_pkg;

   localparam int unsigned TIME_W   = 17;
   localparam int unsigned TPL_W    = 10;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned COLOR_W  = 4;
   localparam int unsigned ROW_W    = 8;
   localparam int unsigned COLUMN_W = 9;
   localparam int unsigned APB_AW   = 3;
   localparam int unsigned APB_DW   = 32;

   localparam logic [TIME_W-1:0] TIME_MAX  = 17'h1FFFF;
   localparam logic [TIME_W-1:0] TBP_RESET = 17'd14336;
   localparam logic [TPL_W-1:0]  TPL_RESET = 10'd224;

   localparam int unsigned SCREEN_BYTES     = 6912;
   localparam int unsigned ATTR_BASE        = 6144;
   localparam int unsigned BANK_DEPTH       = SCREEN_BYTES / 2;
   localparam int unsigned BANK_AW          = 12;
   localparam int unsigned SCREEN_AW        = 13;
   localparam int unsigned PAPER_LINES      = 192;
   localparam int unsigned PAPER_PIXELS     = 256;
   localparam int unsigned FRAME_START_TRIM = 29;

   localparam logic [OP_W-1:0] OP_FRAME_START  = 3'd0;
   localparam logic [OP_W-1:0] OP_BEAM_TICK    = 3'd1;
   localparam logic [OP_W-1:0] OP_PORT_WRITE   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCREEN_WRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_FLASH_TOGGLE = 3'd4;

   localparam logic REG_TICKS_BEFORE_PAPER = 1'b0;
   localparam logic REG_TICKS_PER_LINE     = 1'b1;

   typedef struct packed {
      logic                 enable;
      logic [SCREEN_AW-1:0] address;
      logic [DATA_W-1:0]    data;
   } ram_write_type;

   typedef struct packed {
      logic               enable;
      logic [BANK_AW-1:0] bitmap_even;
      logic [BANK_AW-1:0] bitmap_odd;
      logic [BANK_AW-1:0] attr_even;
      logic [BANK_AW-1:0] attr_odd;
   } ram_read_type;

   typedef struct packed {
      logic [DATA_W-1:0] bitmap_even;
      logic [DATA_W-1:0] bitmap_odd;
      logic [DATA_W-1:0] attr_even;
      logic [DATA_W-1:0] attr_odd;
   } ram_data_type;

   // start of the first visible line, clamped at zero
   function automatic logic [TIME_W-1:0] first_line_start(input logic [TIME_W-1:0] tbp,
                                                         input logic [TPL_W-1:0]  tpl,
                                                         input logic [5:0]        vborder);
      logic [TIME_W-1:0] back;
      back = ({11'd0, vborder} * {7'd0, tpl}) + TIME_W'(FRAME_START_TRIM);
      if (tbp < back) begin
         return '0;
      end
      return tbp - back;
   endfunction

endpackage

/* hdl/svpg_channels.sv */
// valid/ready channel interfaces for requests and pixel pair results
interface svpg_req_if;
   import svpg_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;

   modport source (output valid, output operation, output address, output data, input ready);
   modport sink (input valid, input operation, input address, input data, output ready);
endinterface

interface svpg_rsp_if;
   import svpg_pkg::*;
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  left_color;
   logic [COLOR_W-1:0]  right_color;
   logic [ROW_W-1:0]    row;
   logic [COLUMN_W-1:0] column;

   modport source (output valid, output left_color, output right_color, output row,
                   output column, input ready);
   modport sink (input valid, input left_color, input right_color, input row,
                 input column, output ready);
endinterface

/* hdl/svpg_screen_ram.sv */
// screen memory in two byte banks (even and odd offsets) with a clearing sweep after reset
module svpg_screen_ram
   import svpg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ram_write_type wr,
   input  ram_read_type  rd,
   output ram_data_type  rd_data,
   output logic          busy
);

   logic [DATA_W-1:0]  even_mem [BANK_DEPTH];
   logic [DATA_W-1:0]  odd_mem  [BANK_DEPTH];

   logic               busy_ff;
   logic [BANK_AW-1:0] clear_row_ff;
   ram_data_type       rd_data_ff;

   logic               even_we;
   logic               odd_we;
   logic [BANK_AW-1:0] wr_row;
   logic [DATA_W-1:0]  wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         clear_row_ff <= '0;
      end else if (busy_ff) begin
         clear_row_ff <= clear_row_ff + BANK_AW'(1);
         if (clear_row_ff == BANK_AW'(BANK_DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // both banks are swept together while clearing
   always_comb begin
      even_we = busy_ff || (wr.enable && !wr.address[0]);
      odd_we  = busy_ff || (wr.enable && wr.address[0]);
      wr_row  = busy_ff ? clear_row_ff : wr.address[SCREEN_AW-1:1];
      wr_data = busy_ff ? '0 : wr.data;
   end

   always_ff @(posedge clock) begin
      if (even_we) begin
         even_mem[wr_row] <= wr_data;
      end
      if (odd_we) begin
         odd_mem[wr_row] <= wr_data;
      end
      if (rd.enable) begin
         rd_data_ff.bitmap_even <= even_mem[rd.bitmap_even];
         rd_data_ff.attr_even   <= even_mem[rd.attr_even];
         rd_data_ff.bitmap_odd  <= odd_mem[rd.bitmap_odd];
         rd_data_ff.attr_odd    <= odd_mem[rd.attr_odd];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

/* hdl/spectrum_video_pixel_generator.sv */
// top level: beam timing, screen memory lookup and pixel pair output of the video generator
//
//   channel      dir   handshake             payload
//   req_channel  in    valid/ready           operation, address, data
//   rsp_channel  out   valid/ready           left_color, right_color, row, column
//   apb          in    psel/penable/pwrite   paddr, pwdata -> prdata, pready
//
// one request is taken every cycle while the memory is not clearing and the result path is not
// stalled; a pixel pair reaches the result register through the memory read stage, then colour stage
// after reset the screen memory is swept to zero, all BANK_DEPTH = 3456 rows, and no
// request is taken meanwhile; register writes are taken as ever
// a stalled result holds the colour stage, and requests keep flowing while the
// colour stage can still move into the result register
module spectrum_video_pixel_generator
   import svpg_pkg::*;
#(
   parameter int unsigned VISIBLE_LINES = 240,
   parameter int unsigned LINE_PIXELS   = 320
)
(
   input  logic              clock,
   input  logic              reset,
   svpg_req_if.sink          req_channel,
   svpg_rsp_if.source        rsp_channel,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   localparam int unsigned VBORDER       = (VISIBLE_LINES - PAPER_LINES) / 2;
   localparam int unsigned HBORDER       = (LINE_PIXELS - PAPER_PIXELS) / 2;
   localparam int unsigned VISIBLE_TICKS = (LINE_PIXELS + 1) / 2;
   localparam int unsigned LINE_W        = $clog2(VISIBLE_LINES + 1);

   typedef struct packed {
      logic               paper;
      logic               bank;
      logic [2:0]         bit_sel;
      logic [BANK_AW-1:0] bitmap_row;
      logic [BANK_AW-1:0] attr_row;
   } pix_loc_type;

   typedef struct packed {
      logic       paper;
      logic       bank;
      logic [2:0] bit_sel;
   } pix_sel_type;

   function automatic pix_loc_type pixel_locate(input logic [LINE_W-1:0]   line,
                                                input logic [COLUMN_W-1:0] px);
      pix_loc_type         loc;
      logic [LINE_W-1:0]   ydiff;
      logic [COLUMN_W-1:0] xdiff;
      logic [7:0]          y;
      logic [7:0]          xp;
      logic [9:0]          attr_idx;
      ydiff     = line - LINE_W'(VBORDER);
      xdiff     = px - COLUMN_W'(HBORDER);
      y         = ydiff[7:0];
      xp        = xdiff[7:0];
      attr_idx  = {y[7:3], xp[7:3]};
      loc.paper = (line >= LINE_W'(VBORDER)) && (line < LINE_W'(VBORDER + PAPER_LINES))
                  && (px >= COLUMN_W'(HBORDER)) && (px < COLUMN_W'(HBORDER + PAPER_PIXELS));
      loc.bank       = xp[3];
      loc.bit_sel    = xp[2:0];
      // interleaved bitmap layout: third, pixel line, character row, column
      loc.bitmap_row = {y[7:6], y[2:0], y[5:3], xp[7:4]};
      loc.attr_row   = BANK_AW'(ATTR_BASE / 2) + {3'd0, attr_idx[9:1]};
      return loc;
   endfunction

   function automatic logic [COLOR_W-1:0] pixel_color(input pix_sel_type  sel,
                                                      input ram_data_type mem,
                                                      input logic [2:0]   border,
                                                      input logic         flash);
      logic [DATA_W-1:0] bitmap;
      logic [DATA_W-1:0] attr;
      logic              ink;
      bitmap = sel.bank ? mem.bitmap_odd : mem.bitmap_even;
      attr   = sel.bank ? mem.attr_odd : mem.attr_even;
      ink    = bitmap[3'd7 - sel.bit_sel] ^ (flash & attr[7]);
      if (!sel.paper) begin
         return {1'b0, border};
      end
      return ink ? {attr[6], attr[2:0]} : attr[6:3];
   endfunction

   // configuration registers
   logic [TIME_W-1:0] tbp_ff;
   logic [TPL_W-1:0]  tpl_ff;
   logic              cfg_write;

   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_TICKS_PER_LINE) ? {22'd0, tpl_ff} : {15'd0, tbp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tbp_ff <= TBP_RESET;
         tpl_ff <= TPL_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_TICKS_PER_LINE) begin
            tpl_ff <= pwdata[TPL_W-1:0];
         end else begin
            tbp_ff <= pwdata[TIME_W-1:0];
         end
      end
   end

   // beam state
   logic [TIME_W-1:0] tick_count_ff, tick_count_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [TIME_W-1:0] line_begin_ff, line_begin_in;
   logic [2:0]        border_ff, border_in;
   logic              flash_ff, flash_in;

   logic              accept;
   logic [OP_W-1:0]   op;
   logic              is_tick;
   logic              line_live;
   logic [TIME_W-1:0] offset;
   logic [TPL_W-1:0]  period;
   logic              emit;
   logic              line_done;
   logic [TIME_W:0]   next_begin;
   logic [COLUMN_W-1:0] pair_x;
   pix_loc_type       left_loc;
   pix_loc_type       right_loc;

   ram_write_type     ram_wr;
   ram_read_type      ram_rd;
   ram_data_type      ram_data;
   logic              ram_busy;

   // colour stage and result register
   logic              s1_valid_ff, s1_valid_in;
   pix_sel_type       s1_left_ff;
   pix_sel_type       s1_right_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COLUMN_W-1:0] s1_col_ff;
   logic [2:0]        s1_border_ff;
   logic              s1_flash_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_left_ff;
   logic [COLOR_W-1:0] rsp_right_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COLUMN_W-1:0] rsp_col_ff;

   logic              out_free;
   logic              advance;

   assign out_free          = !rsp_valid_ff || rsp_channel.ready;
   assign advance           = s1_valid_ff && out_free;
   assign req_channel.ready = !ram_busy && (!s1_valid_ff || out_free);
   assign accept            = req_channel.valid && req_channel.ready;
   assign op                = req_channel.operation;
   assign is_tick           = (op == OP_BEAM_TICK);

   always_comb begin
      line_live  = (line_ff < LINE_W'(VISIBLE_LINES)) && (tick_count_ff >= line_begin_ff);
      offset     = tick_count_ff - line_begin_ff;
      period     = (tpl_ff < TPL_W'(VISIBLE_TICKS)) ? TPL_W'(VISIBLE_TICKS) : tpl_ff;
      emit       = line_live && ({offset, 1'b0} < (TIME_W + 1)'(LINE_PIXELS));
      line_done  = line_live && (({1'b0, offset} + 18'd1) >= {8'd0, period});
      next_begin = {1'b0, line_begin_ff} + {8'd0, period};
      pair_x     = {offset[7:0], 1'b0};
      left_loc   = pixel_locate(line_ff, pair_x);
      right_loc  = pixel_locate(line_ff, pair_x + COLUMN_W'(1));
   end

   always_comb begin
      tick_count_in = tick_count_ff;
      line_in       = line_ff;
      line_begin_in = line_begin_ff;
      border_in     = border_ff;
      flash_in      = flash_ff;
      if (accept) begin
         case (op)
            OP_FRAME_START: begin
               tick_count_in = '0;
               line_in       = '0;
               line_begin_in = first_line_start(tbp_ff, tpl_ff, 6'(VBORDER));
            end
            OP_BEAM_TICK: begin
               if (line_done) begin
                  if (next_begin[TIME_W]) begin
                     // time ran past the counter range: frame is over
                     line_in = LINE_W'(VISIBLE_LINES);
                  end else begin
                     line_in       = line_ff + LINE_W'(1);
                     line_begin_in = next_begin[TIME_W-1:0];
                  end
               end
               if (tick_count_ff != TIME_MAX) begin
                  tick_count_in = tick_count_ff + TIME_W'(1);
               end
            end
            OP_PORT_WRITE: begin
               if (!req_channel.address[0]) begin
                  border_in = req_channel.data[2:0];
               end
            end
            OP_FLASH_TOGGLE: begin
               flash_in = !flash_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         line_ff       <= '0;
         line_begin_ff <= first_line_start(TBP_RESET, TPL_RESET, 6'(VBORDER));
         border_ff     <= '0;
         flash_ff      <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         line_ff       <= line_in;
         line_begin_ff <= line_begin_in;
         border_ff     <= border_in;
         flash_ff      <= flash_in;
      end
   end

   // the two pixels of a pair may fall in neighbouring bytes, which sit in opposite banks
   always_comb begin
      ram_wr.enable  = accept && (op == OP_SCREEN_WRITE)
                       && (req_channel.address < ADDR_W'(SCREEN_BYTES));
      ram_wr.address = req_channel.address[SCREEN_AW-1:0];
      ram_wr.data    = req_channel.data;

      ram_rd.enable      = accept;
      ram_rd.bitmap_even = (left_loc.paper && !left_loc.bank) ? left_loc.bitmap_row
                                                               : right_loc.bitmap_row;
      ram_rd.attr_even   = (left_loc.paper && !left_loc.bank) ? left_loc.attr_row
                                                               : right_loc.attr_row;
      ram_rd.bitmap_odd  = (left_loc.paper && left_loc.bank) ? left_loc.bitmap_row
                                                              : right_loc.bitmap_row;
      ram_rd.attr_odd    = (left_loc.paper && left_loc.bank) ? left_loc.attr_row
                                                              : right_loc.attr_row;
   end

   svpg_screen_ram u_screen_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_data),
      .busy    (ram_busy)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = is_tick && emit;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // border colour and flash phase are taken with the tick
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_left_ff   <= '{paper: left_loc.paper, bank: left_loc.bank,
                           bit_sel: left_loc.bit_sel};
         s1_right_ff  <= '{paper: right_loc.paper, bank: right_loc.bank,
                           bit_sel: right_loc.bit_sel};
         s1_row_ff    <= line_ff[ROW_W-1:0];
         s1_col_ff    <= pair_x;
         s1_border_ff <= border_ff;
         s1_flash_ff  <= flash_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_left_ff  <= pixel_color(s1_left_ff, ram_data, s1_border_ff, s1_flash_ff);
         rsp_right_ff <= pixel_color(s1_right_ff, ram_data, s1_border_ff, s1_flash_ff);
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
      end
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.left_color  = rsp_left_ff;
   assign rsp_channel.right_color = rsp_right_ff;
   assign rsp_channel.row         = rsp_row_ff;
   assign rsp_channel.column      = rsp_col_ff;

   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> !req_channel.ready)
      else $error("request taken during memory clear");

   a_line_in_range: assert property (@(posedge clock) disable iff (reset)
      line_ff <= LINE_W'(VISIBLE_LINES))
      else $error("line counter past the frame");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick && (tick_count_ff != TIME_MAX))
      |=> (tick_count_ff == $past(tick_count_ff) + TIME_W'(1)))
      else $error("tick counter did not advance");

   a_emit_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick && emit) |=> s1_valid_ff)
      else $error("visible tick lost before colour stage");

   a_result_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_col_ff[0] && (rsp_col_ff < COLUMN_W'(LINE_PIXELS))))
      else $error("result column out of place");

endmodule
